@@ rtl/frq_pkg.sv @@
// ----------------------------------------------------------------------------
// frq_pkg
// Shared types and constants of the run queue: operation codes, field
// widths and the layout of a result transaction.
// ----------------------------------------------------------------------------
package frq_pkg;

    localparam int PROC_W  = 6;
    localparam int COUNT_W = 7;
    localparam int SLICE_W = 15;
    localparam int BASE_W  = 8;
    localparam int SliceScale = 100;

    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    localparam logic [2:0] ADDR_BASE_SLICE = 3'd0;

    typedef logic [PROC_W-1:0]  proc_id_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SLICE_W-1:0] slice_t;
    typedef logic [BASE_W-1:0]  base_t;

    // Packed so that the first field lands in the highest bits.
    typedef struct packed {
        logic     op_error;
        logic     resched_flag;
        count_t   queue_count;
        proc_id_t head_id;
        logic     head_valid;
    } result_t;

    // Per-process word in the state memory.
    typedef struct packed {
        logic   in_queue;
        slice_t slice_left;
    } entry_t;

endpackage

@@ rtl/frq_ram.sv @@
// ----------------------------------------------------------------------------
// frq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/frq_apb.sv @@
// ----------------------------------------------------------------------------
// frq_apb
// Configuration register file: holds base_slice behind an APB-style port.
// ----------------------------------------------------------------------------
module frq_apb (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output frq_pkg::base_t  base_slice
);

    frq_pkg::base_t base_slice_reg;
    logic           wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == frq_pkg::ADDR_BASE_SLICE[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_slice_reg <= frq_pkg::base_t'(5);
        end else if (wr_hit) begin
            base_slice_reg <= pwdata[frq_pkg::BASE_W-1:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == frq_pkg::ADDR_BASE_SLICE[2]) begin
            prdata = {{(32-frq_pkg::BASE_W){1'b0}}, base_slice_reg};
        end
    end

    assign base_slice = base_slice_reg;

endmodule

@@ rtl/fifo_run_queue_with_time_slice.sv @@
// ----------------------------------------------------------------------------
// fifo_run_queue_with_time_slice
// Run queue of process numbers in arrival order with per-process time slice.
// ----------------------------------------------------------------------------
// In IDLE the link memories and the per-process state memory are read at the
// named process; in EXEC the entry is modified and written back and the result
// registered, holding while the output register still has an untaken result.
// A finished result may wait at the output while the next transaction is
// accepted. After reset the block clears the state memory entry by entry and
// holds s_tready low; configuration writes are taken throughout.
module fifo_run_queue_with_time_slice #(
    parameter int MAX_PROCS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] mode, [7:2] proc_id
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] head_valid, [6:1] head_id,
                                   // [13:7] queue_count, [14] resched_flag,
                                   // [15] op_error
);

    localparam int IDX_W = $clog2(MAX_PROCS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    frq_pkg::base_t   base_slice;
    logic [1:0]       state_reg, state_next;
    idx_t             clr_addr_reg, clr_addr_next;
    logic [1:0]       mode_reg, mode_next;
    frq_pkg::proc_id_t id_reg, id_next;
    idx_t             head_reg, head_next;
    idx_t             tail_reg, tail_next;
    frq_pkg::count_t  count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    frq_pkg::result_t out_reg, out_next;

    idx_t             rd_addr;
    idx_t             id_idx;
    logic             oob;
    logic             go;
    frq_pkg::entry_t  ent_rd, ent_wr;
    logic             ent_we;
    idx_t             ent_waddr;
    idx_t             nxt_rd, prv_rd;
    logic             nxt_we, prv_we;
    idx_t             nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
    frq_pkg::slice_t  slice_load;
    frq_pkg::slice_t  slice_dec;
    logic             err, resched;

    frq_apb u_apb (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .base_slice (base_slice)
    );

    frq_ram #(.WIDTH($bits(frq_pkg::entry_t)), .DEPTH(MAX_PROCS)) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wr),
        .rd_addr (rd_addr),
        .rd_data (ent_rd)
    );

    frq_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCS)) u_next_ram (
        .aclk    (aclk),
        .wr_en   (nxt_we),
        .wr_addr (nxt_waddr),
        .wr_data (nxt_wdata),
        .rd_addr (rd_addr),
        .rd_data (nxt_rd)
    );

    frq_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCS)) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (prv_we),
        .wr_addr (prv_waddr),
        .wr_data (prv_wdata),
        .rd_addr (rd_addr),
        .rd_data (prv_rd)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Address follows the incoming transaction in IDLE and holds during EXEC.
    assign rd_addr = (state_reg == ST_IDLE) ? idx_t'(s_tdata[7:2]) : idx_t'(id_reg);
    assign id_idx  = idx_t'(id_reg);
    assign oob     = (32'(id_reg) >= MAX_PROCS);
    assign go      = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    assign slice_load = frq_pkg::slice_t'(base_slice) *
                        frq_pkg::slice_t'(frq_pkg::SliceScale);
    assign slice_dec  = (ent_rd.slice_left != '0) ? ent_rd.slice_left - 1'b1 : '0;

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        mode_next      = mode_reg;
        id_next        = id_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ent_we         = 1'b0;
        ent_waddr      = id_idx;
        ent_wr         = ent_rd;
        nxt_we         = 1'b0;
        nxt_waddr      = tail_reg;
        nxt_wdata      = id_idx;
        prv_we         = 1'b0;
        prv_waddr      = id_idx;
        prv_wdata      = tail_reg;
        err            = 1'b0;
        resched        = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ent_we        = 1'b1;
                ent_waddr     = clr_addr_reg;
                ent_wr        = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == idx_t'(MAX_PROCS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next  = s_tdata[1:0];
                    id_next    = s_tdata[7:2];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (mode_reg)
                    frq_pkg::MODE_ENQ: begin
                        if (oob || ent_rd.in_queue) begin
                            err = 1'b1;
                        end else begin
                            ent_we = 1'b1;
                            ent_wr = '{in_queue: 1'b1, slice_left: slice_load};
                            if (count_reg == '0) begin
                                head_next = id_idx;
                            end else begin
                                // link behind the current tail
                                nxt_we = 1'b1;
                                prv_we = 1'b1;
                            end
                            tail_next  = id_idx;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    frq_pkg::MODE_DEQ: begin
                        if (oob || !ent_rd.in_queue) begin
                            err = 1'b1;
                        end else begin
                            ent_we = 1'b1;
                            ent_wr = '{in_queue: 1'b0, slice_left: ent_rd.slice_left};
                            if (count_reg <= frq_pkg::count_t'(1)) begin
                                head_next = '0;
                                tail_next = '0;
                            end else if (id_idx == head_reg) begin
                                head_next = nxt_rd;
                            end else if (id_idx == tail_reg) begin
                                tail_next = prv_rd;
                            end else begin
                                // splice neighbors around the removed entry
                                nxt_we    = 1'b1;
                                nxt_waddr = prv_rd;
                                nxt_wdata = nxt_rd;
                                prv_we    = 1'b1;
                                prv_waddr = nxt_rd;
                                prv_wdata = prv_rd;
                            end
                            if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                    frq_pkg::MODE_TICK: begin
                        if (!oob) begin
                            ent_we  = 1'b1;
                            ent_wr  = '{in_queue: ent_rd.in_queue, slice_left: slice_dec};
                            resched = (slice_dec == '0);
                        end
                    end
                    frq_pkg::MODE_NOP: begin
                    end
                    default: begin
                    end
                endcase

                if (!go) begin
                    // hold until the output register frees up
                    ent_we     = 1'b0;
                    nxt_we     = 1'b0;
                    prv_we     = 1'b0;
                    head_next  = head_reg;
                    tail_next  = tail_reg;
                    count_next = count_reg;
                end else begin
                    out_valid_next        = 1'b1;
                    out_next.head_valid   = (count_next != '0);
                    out_next.head_id      = (count_next != '0) ?
                                            frq_pkg::proc_id_t'(head_next) : '0;
                    out_next.queue_count  = count_next;
                    out_next.resched_flag = resched;
                    out_next.op_error     = err;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        id_reg   <= id_next;
        out_reg  <= out_next;
    end

endmodule
